FILE: src/boxds_pkg.sv
// Shared constants and types for the box average downscaler.
`timescale 1ns / 1ps

package boxds_pkg;

    localparam int MAX_LINE_WIDTH = 4096;
    localparam int BLOCK_HEIGHT   = 4;
    localparam int STORE_DEPTH    = MAX_LINE_WIDTH / 4;
    localparam int ADDR_W         = $clog2(STORE_DEPTH);
    localparam int COL_W          = $clog2(MAX_LINE_WIDTH);
    localparam int LW_W           = 13;
    localparam int PIX_W          = 8;
    localparam int HSUM_W         = 11;
    localparam int SUM_W          = 13;
    localparam int MEAN_W         = 13;
    localparam int BAND_W         = $clog2(BLOCK_HEIGHT);
    localparam int OUTQ_DEPTH     = 3;
    localparam int OUTQ_PTR_W     = $clog2(OUTQ_DEPTH);
    localparam int OUTQ_CNT_W     = $clog2(OUTQ_DEPTH + 1);

    localparam logic [LW_W-1:0] LINE_WIDTH_RESET = LW_W'(640);

    typedef enum logic {
        REG_LINE_WIDTH = 1'b0,
        REG_BLOCK_MODE = 1'b1
    } t_reg_index;

    typedef struct packed {
        logic [MEAN_W-1:0] block_mean;
        logic              row_end;
    } t_result;

endpackage

FILE: src/boxds_ram.sv
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps

module boxds_ram #(
    parameter int WIDTH = 13,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/boxds_outq.sv
// Small result queue that decouples the output handshake from the pipeline.
`timescale 1ns / 1ps

module boxds_outq (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_push,
    input  boxds_pkg::t_result                  i_data,
    output logic                                o_valid,
    input  logic                                i_ready,
    output boxds_pkg::t_result                  o_data,
    output logic [boxds_pkg::OUTQ_CNT_W-1:0]    o_count
);

    import boxds_pkg::*;

    t_result                 r_mem [OUTQ_DEPTH];
    logic [OUTQ_PTR_W-1:0]   r_wptr;
    logic [OUTQ_PTR_W-1:0]   r_rptr;
    logic [OUTQ_CNT_W-1:0]   r_count;
    logic                    pop;

    assign o_valid = (r_count != '0);
    assign pop     = o_valid && i_ready;
    assign o_data  = r_mem[r_rptr];
    assign o_count = r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == OUTQ_PTR_W'(OUTQ_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (pop) begin
                r_rptr <= (r_rptr == OUTQ_PTR_W'(OUTQ_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (i_push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push && !pop |-> r_count < OUTQ_CNT_W'(OUTQ_DEPTH))
        else $error("result queue overflow");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> r_count != '0)
        else $error("result queue underflow");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= OUTQ_CNT_W'(OUTQ_DEPTH))
        else $error("result queue count out of range");

endmodule

FILE: src/box_average_downscale.sv
// Top level of the box average downscaler: 4x4 or 8x4 block means of a pixel stream.
`timescale 1ns / 1ps

// Pixels enter in raster order, one word per clock with no bubbles required, and every
// pixel that closes a block on the fourth row of its band yields one result word: the
// block mean in unsigned Q8.5, with tlast set on the last block of a line. A result word
// is registered in the second stage and then in the result queue before it is valid on
// the output. Per-column partial sums live in a 1024-entry single-port-write RAM with a
// registered read; each pixel that ends a block reads its entry in the cycle it is taken
// and writes the updated sum in the cycle after, and a forwarding register covers a read
// that meets the write to the same entry. A three-word result queue lets input continue
// while results wait at the output; input stalls only when the results held in the queue
// and the second stage add up to three. The RAM is not cleared: the first band after a
// frame start overwrites its entries. Configuration must be written only while the block
// is idle; the block itself does not enforce this.

module box_average_downscale (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [7:0]                      s_axis_tdata,   // [7:0] pixel
    input  logic                            s_axis_tuser,   // [0] frame_start
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [15:0]                     m_axis_tdata,   // [12:0] block_mean, [15:13] zero
    output logic                            m_axis_tlast,   // row_end
    input  logic                            i_cfg_we,
    input  boxds_pkg::t_reg_index           i_cfg_addr,
    input  logic [boxds_pkg::LW_W-1:0]      i_cfg_data
);

    import boxds_pkg::*;

    typedef struct packed {
        logic [ADDR_W-1:0] idx;
        logic [HSUM_W-1:0] hsum;
        logic              first_row;
        logic              emit;
        logic              row_end;
        logic              block_end;
        logic              mode;
    } t_stage;

    logic [LW_W-1:0]       r_line_width;
    logic                  r_mode;
    logic [COL_W-1:0]      r_col;
    logic [BAND_W-1:0]     r_band;
    logic [HSUM_W-1:0]     r_hsum;
    logic                  r_s1_valid;
    t_stage                r_s1;
    logic                  r_fwd_v;
    logic [ADDR_W-1:0]     r_fwd_addr;
    logic [SUM_W-1:0]      r_fwd_data;

    logic                  accept;
    logic [COL_W-1:0]      col0;
    logic [BAND_W-1:0]     band0;
    logic [2:0]            bw_mask;
    logic [2:0]            low;
    logic                  last_px;
    logic [LW_W-1:0]       bw_full;
    logic [LW_W-1:0]       w_trunc;
    logic [LW_W-1:0]       width;
    logic [LW_W-1:0]       width_m1;
    logic                  line_end;
    logic [HSUM_W-1:0]     hsum_n;
    logic [ADDR_W-1:0]     idx0;
    t_stage                n_s1;
    logic [SUM_W-1:0]      ram_q;
    logic [SUM_W-1:0]      prior;
    logic [SUM_W-1:0]      sum;
    logic                  wr_en;
    logic                  q_push;
    t_result               q_in;
    t_result               q_out;
    logic [OUTQ_CNT_W-1:0] q_count;
    logic [OUTQ_CNT_W:0]   pending;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width <= LINE_WIDTH_RESET;
            r_mode       <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_LINE_WIDTH: r_line_width <= i_cfg_data;
                REG_BLOCK_MODE: r_mode       <= i_cfg_data[0];
                default:        r_mode       <= r_mode;
            endcase
        end
    end

    assign pending       = (OUTQ_CNT_W + 1)'(q_count)
                         + (OUTQ_CNT_W + 1)'(r_s1_valid && r_s1.emit);
    assign s_axis_tready = pending < (OUTQ_CNT_W + 1)'(OUTQ_DEPTH);
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb begin
        col0     = s_axis_tuser ? '0 : r_col;
        band0    = s_axis_tuser ? '0 : r_band;
        bw_mask  = r_mode ? 3'd7 : 3'd3;
        low      = col0[2:0] & bw_mask;
        last_px  = (low == bw_mask);
        bw_full  = LW_W'(bw_mask) + 1'b1;
        w_trunc  = r_line_width & ~LW_W'(bw_mask);
        if (w_trunc < bw_full) begin
            width = bw_full;
        end else if (w_trunc > LW_W'(MAX_LINE_WIDTH)) begin
            width = LW_W'(MAX_LINE_WIDTH);
        end else begin
            width = w_trunc;
        end
        width_m1 = width - 1'b1;
        line_end = LW_W'(col0) >= width_m1;
        hsum_n   = (low == 3'd0) ? HSUM_W'(s_axis_tdata)
                                 : r_hsum + HSUM_W'(s_axis_tdata);
        idx0     = r_mode ? ADDR_W'(col0 >> 3) : ADDR_W'(col0 >> 2);

        n_s1.idx       = idx0;
        n_s1.hsum      = hsum_n;
        n_s1.first_row = (band0 == '0);
        n_s1.block_end = line_end || last_px;
        n_s1.emit      = (line_end || last_px) && (band0 == BAND_W'(BLOCK_HEIGHT - 1));
        n_s1.row_end   = line_end;
        n_s1.mode      = r_mode;
    end

    always_ff @(posedge i_clk) begin
        r_s1       <= n_s1;
        r_fwd_addr <= r_s1.idx;
        r_fwd_data <= sum;
        if (!i_rst_n) begin
            r_col      <= '0;
            r_band     <= '0;
            r_hsum     <= '0;
            r_s1_valid <= 1'b0;
            r_fwd_v    <= 1'b0;
        end else begin
            r_s1_valid <= accept;
            r_fwd_v    <= wr_en;
            if (accept) begin
                r_hsum <= hsum_n;
                if (line_end) begin
                    r_col  <= '0;
                    r_band <= band0 + 1'b1;
                end else begin
                    r_col  <= col0 + 1'b1;
                    r_band <= band0;
                end
            end
        end
    end

    boxds_ram #(
        .WIDTH (SUM_W),
        .DEPTH (STORE_DEPTH)
    ) u_col_store (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_s1.idx),
        .i_wdata (sum),
        .i_raddr (idx0),
        .o_rdata (ram_q)
    );

    always_comb begin
        prior = (r_fwd_v && (r_fwd_addr == r_s1.idx)) ? r_fwd_data : ram_q;
        sum   = r_s1.first_row ? SUM_W'(r_s1.hsum) : prior + SUM_W'(r_s1.hsum);
        wr_en = r_s1_valid && r_s1.block_end;
        q_push          = r_s1_valid && r_s1.emit;
        q_in.block_mean = r_s1.mode ? MEAN_W'(sum) : MEAN_W'({sum, 1'b0});
        q_in.row_end    = r_s1.row_end;
    end

    boxds_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (q_out),
        .o_count (q_count)
    );

    assign m_axis_tdata = {3'b000, q_out.block_mean};
    assign m_axis_tlast = q_out.row_end;

    a_accept_to_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_s1_valid)
        else $error("accepted word did not reach the second stage");

    a_pending_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pending <= (OUTQ_CNT_W + 1)'(OUTQ_DEPTH))
        else $error("more results in flight than queue space");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && !r_s1_valid)
        else $error("pipeline not empty after reset");

    a_emit_writes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> wr_en)
        else $error("result produced without a store update");

endmodule

FILE: sim/box_average_downscale_checker.sv
// Checker for the box average downscaler: predicts each block mean from the accepted pixels and compares.
`timescale 1ns / 1ps

module box_average_downscale_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_pix_valid,
    input  logic                         i_pix_ready,
    input  logic [7:0]                   i_pix_data,         // [7:0] pixel
    input  logic                         i_pix_frame_start,  // [0] frame_start
    input  logic                         i_mean_valid,
    input  logic                         i_mean_ready,
    input  logic [15:0]                  i_mean_data,        // [12:0] block_mean, [15:13] zero
    input  logic                         i_mean_last,        // row_end
    input  logic                         i_cfg_we,
    input  boxds_pkg::t_reg_index        i_cfg_addr,
    input  logic [boxds_pkg::LW_W-1:0]   i_cfg_data,
    output int                           o_fail_count,
    output int                           o_pending,
    output int                           o_checked
);

    localparam int LW_W   = boxds_pkg::LW_W;
    localparam int SUM_W  = boxds_pkg::SUM_W;
    localparam int MEAN_W = boxds_pkg::MEAN_W;
    localparam int HSUM_W = boxds_pkg::HSUM_W;
    localparam int COL_W  = boxds_pkg::COL_W;
    localparam int BAND_W = boxds_pkg::BAND_W;

    logic [LW_W-1:0]   line_width_reg;
    logic              wide_mode;
    logic [SUM_W-1:0]  column_sums [0:boxds_pkg::STORE_DEPTH-1];
    logic [HSUM_W-1:0] row_sum;
    logic [COL_W-1:0]  column;
    logic [BAND_W-1:0] band_row;

    boxds_pkg::t_result mean_queue [$];
    boxds_pkg::t_result oldest;

    function automatic int effective_width(input logic [LW_W-1:0] lw, input logic wide);
        int bw;
        int w;
        bw = wide ? 8 : 4;
        w = int'(lw) & ~(bw - 1);
        if (w < bw) w = bw;
        if (w > boxds_pkg::MAX_LINE_WIDTH) w = boxds_pkg::MAX_LINE_WIDTH;
        return w;
    endfunction

    task automatic accumulate_pixel(input logic [7:0] pix, input logic frame_start);
        int bw;
        int width;
        int slot;
        logic line_end;
        logic block_end;
        logic [SUM_W-1:0] total;
        boxds_pkg::t_result res;
        bw = wide_mode ? 8 : 4;
        width = effective_width(line_width_reg, wide_mode);
        if (frame_start) begin
            column = '0;
            band_row = '0;
        end
        line_end = (int'(column) >= width - 1);
        if (int'(column) % bw == 0) begin
            row_sum = HSUM_W'(pix);
        end else begin
            row_sum = row_sum + HSUM_W'(pix);
        end
        block_end = line_end || (int'(column) % bw == bw - 1);
        if (block_end) begin
            slot = (int'(column) / bw) % boxds_pkg::STORE_DEPTH;
            if (band_row == '0) begin
                total = SUM_W'(row_sum);
            end else begin
                total = column_sums[slot] + SUM_W'(row_sum);
            end
            column_sums[slot] = total;
            if (band_row == BAND_W'(boxds_pkg::BLOCK_HEIGHT - 1)) begin
                // A 4x4 sum is doubled to reach five fraction bits; an 8x4 sum already has them.
                res.block_mean = wide_mode ? total : MEAN_W'(total << 1);
                res.row_end = line_end;
                mean_queue.push_back(res);
            end
        end
        if (line_end) begin
            column = '0;
            band_row = band_row + 1'b1;
        end else begin
            column = column + 1'b1;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            line_width_reg = boxds_pkg::LINE_WIDTH_RESET;
            wide_mode = 1'b0;
            row_sum = '0;
            column = '0;
            band_row = '0;
            mean_queue.delete();
            o_fail_count = 0;
            o_pending = 0;
            o_checked = 0;
        end else begin
            if (i_mean_valid && i_mean_ready) begin
                if (mean_queue.size() == 0) begin
                    $error("block result with no prediction waiting: block_mean %0d, row_end %0b",
                           i_mean_data[MEAN_W-1:0], i_mean_last);
                    o_fail_count++;
                end else begin
                    oldest = mean_queue.pop_front();
                    o_checked++;
                    if (i_mean_data[MEAN_W-1:0] !== oldest.block_mean) begin
                        $error("block_mean mismatch: expected %0d, actual %0d",
                               oldest.block_mean, i_mean_data[MEAN_W-1:0]);
                        o_fail_count++;
                    end
                    if (i_mean_last !== oldest.row_end) begin
                        $error("row_end mismatch: expected %0b, actual %0b",
                               oldest.row_end, i_mean_last);
                        o_fail_count++;
                    end
                end
            end
            if (i_pix_valid && i_pix_ready) begin
                accumulate_pixel(i_pix_data, i_pix_frame_start);
            end
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    boxds_pkg::REG_LINE_WIDTH: line_width_reg = i_cfg_data;
                    boxds_pkg::REG_BLOCK_MODE: wide_mode = i_cfg_data[0];
                    default: ;
                endcase
            end
            o_pending = mean_queue.size();
        end
    end

endmodule

FILE: sim/tb_box_average_downscale.sv
// Testbench top for the box average downscaler: pixel stimulus, register settings and verdict.
`timescale 1ns / 1ps

module tb_box_average_downscale;

    import boxds_pkg::*;

    localparam int PIXELS_WANTED = 950;
    localparam int CYCLE_LIMIT   = 600000;

    logic              i_clk;
    logic              i_rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [7:0]        s_axis_tdata;   // [7:0] pixel
    logic              s_axis_tuser;   // [0] frame_start
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [15:0]       m_axis_tdata;   // [12:0] block_mean, [15:13] zero
    logic              m_axis_tlast;   // row_end
    logic              i_cfg_we;
    t_reg_index        i_cfg_addr;
    logic [LW_W-1:0]   i_cfg_data;

    int fail_count;
    int means_pending;
    int means_checked;

    // Position tracking on the sending side, used only to keep reads off unwritten entries.
    logic [LW_W-1:0] lw_now;
    logic            wide_now;
    int              trk_column;
    int              trk_band;
    bit              filled [0:STORE_DEPTH-1];

    bit steady;
    int burst_left;
    int pixels_sent;
    int settings_used;
    int cycles;
    int ready_left;
    int ready_pick;

    box_average_downscale DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data)
    );

    box_average_downscale_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_pix_valid       (s_axis_tvalid),
        .i_pix_ready       (s_axis_tready),
        .i_pix_data        (s_axis_tdata),
        .i_pix_frame_start (s_axis_tuser),
        .i_mean_valid      (m_axis_tvalid),
        .i_mean_ready      (m_axis_tready),
        .i_mean_data       (m_axis_tdata),
        .i_mean_last       (m_axis_tlast),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_addr        (i_cfg_addr),
        .i_cfg_data        (i_cfg_data),
        .o_fail_count      (fail_count),
        .o_pending         (means_pending),
        .o_checked         (means_checked)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Run stopped after %0d cycles with %0d results outstanding.",
                     cycles, means_pending);
            $display("** box_average_downscale: FAILED **");
            $finish;
        end
    end

    // The receiver mixes random short ready and stall runs, with an occasional long ready run.
    always @(posedge i_clk) begin
        if (ready_left == 0) begin
            ready_pick = $urandom_range(0, 9);
            if (ready_pick < 5) begin
                m_axis_tready <= 1'b1;
                ready_left = $urandom_range(1, 12);
            end else if (ready_pick < 9) begin
                m_axis_tready <= 1'b0;
                ready_left = $urandom_range(1, 6);
            end else begin
                m_axis_tready <= 1'b1;
                ready_left = $urandom_range(50, 200);
            end
        end else begin
            ready_left--;
        end
    end

    function automatic int effective_width(input logic [LW_W-1:0] lw, input logic wide);
        int bw;
        int w;
        bw = wide ? 8 : 4;
        w = int'(lw) & ~(bw - 1);
        if (w < bw) w = bw;
        if (w > MAX_LINE_WIDTH) w = MAX_LINE_WIDTH;
        return w;
    endfunction

    function automatic logic [7:0] pick_pixel(input int flavor);
        case (flavor)
            0: return 8'($urandom_range(0, 255));
            1: return 8'hFF;
            2: return ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
            default: return 8'($urandom_range(0, 3));
        endcase
    endfunction

    task automatic set_config(input logic [LW_W-1:0] lw, input logic wide);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= REG_LINE_WIDTH;
        i_cfg_data <= lw;
        @(posedge i_clk);
        i_cfg_addr <= REG_BLOCK_MODE;
        i_cfg_data <= LW_W'(wide);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        lw_now = lw;
        wide_now = wide;
        settings_used++;
    endtask

    task automatic send_pixel(input logic [7:0] pix, input logic frame_req);
        int bw;
        int width;
        int col;
        int band;
        int slot;
        logic frame_start;
        logic line_end;
        logic block_end;
        bw = wide_now ? 8 : 4;
        width = effective_width(lw_now, wide_now);
        frame_start = frame_req;
        col = frame_start ? 0 : trk_column;
        band = frame_start ? 0 : trk_band;
        line_end = (col >= width - 1);
        block_end = line_end || (col % bw == bw - 1);
        slot = (col / bw) % STORE_DEPTH;
        // A word that would add to a never-written column sum starts a new frame instead.
        if (block_end && band != 0 && !filled[slot]) begin
            frame_start = 1'b1;
            col = 0;
            band = 0;
            line_end = 1'b0;
            block_end = 1'b0;
        end
        if (block_end) filled[slot] = 1'b1;
        if (line_end) begin
            trk_column = 0;
            trk_band = (band + 1) % BLOCK_HEIGHT;
        end else begin
            trk_column = (col + 1) % MAX_LINE_WIDTH;
            trk_band = band;
        end

        if (!steady && burst_left == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = $urandom_range(1, 16);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pix;
        s_axis_tuser  <= frame_start;
        do @(posedge i_clk); while (!s_axis_tready);
        if (burst_left > 0) burst_left--;
        pixels_sent++;
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (means_pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    initial begin
        int bw;
        int width;
        int count;
        int style;
        int flavor;
        int random_pixels;
        logic [LW_W-1:0] lw;
        logic wide;

        i_clk = 1'b0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        m_axis_tready = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_addr = REG_LINE_WIDTH;
        i_cfg_data = '0;
        lw_now = LINE_WIDTH_RESET;
        wide_now = 1'b0;
        trk_column = 0;
        trk_band = 0;
        foreach (filled[k]) filled[k] = 1'b0;
        steady = 1'b0;
        burst_left = 0;
        pixels_sent = 0;
        settings_used = 0;
        cycles = 0;
        ready_left = 0;
        random_pixels = 0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Two 4x4 blocks per line: the left one saturated, the right one black.
        set_config(LW_W'(8), 1'b0);
        for (int i = 0; i < 32; i++) send_pixel((i % 8 < 4) ? 8'hFF : 8'h00, i == 0);
        drain();

        // The line shrinks and the block widens while the column sits past the new line end.
        set_config(LW_W'(16), 1'b0);
        for (int i = 0; i < 14; i++) send_pixel(pick_pixel(0), i == 0);
        drain();
        set_config(LW_W'(8), 1'b1);
        for (int i = 0; i < 10; i++) send_pixel(pick_pixel(0), 1'b0);
        drain();

        // An all-ones width clamps to the widest line, so these words never reach a line end.
        set_config('1, 1'b0);
        for (int i = 0; i < 24; i++) send_pixel(pick_pixel(0), i == 0);
        drain();

        while (pixels_sent < PIXELS_WANTED) begin
            wide = 1'($urandom_range(0, 1));
            bw = wide ? 8 : 4;
            style = $urandom_range(0, 3);
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: lw = LW_W'(bw * $urandom_range(2, 8));
                6: lw = LW_W'($urandom_range(0, 15));
                7: lw = LW_W'(bw * $urandom_range(1, 8) + $urandom_range(1, bw - 1));
                8: lw = LW_W'(bw * $urandom_range(9, 16));
                default: begin
                    lw = LW_W'($urandom_range(MAX_LINE_WIDTH, 8191));
                    style = 3;
                end
            endcase
            set_config(lw, wide);
            steady = ($urandom_range(0, 3) == 0);
            flavor = ($urandom_range(0, 5) < 3) ? 0 : $urandom_range(1, 3);
            if (style < 3) begin
                width = effective_width(lw, wide);
                count = BLOCK_HEIGHT * width * ((width > 64) ? 1 : $urandom_range(1, 2));
            end else begin
                count = $urandom_range(1, 60);
            end
            if (count > PIXELS_WANTED - pixels_sent) count = PIXELS_WANTED - pixels_sent;
            for (int i = 0; i < count; i++) begin
                send_pixel(pick_pixel(flavor),
                           (style < 3) ? (i == 0) : ($urandom_range(0, 19) == 0));
            end
            random_pixels += count;
            drain();
        end

        $display("Sent %0d pixels under %0d register settings, %0d of them in random phases.",
                 pixels_sent, settings_used, random_pixels);
        $display("Compared %0d block means under sender bursts and receiver stalls.",
                 means_checked);
        if (fail_count == 0) begin
            $display("** box_average_downscale: PASSED **");
        end else begin
            $display("** box_average_downscale: FAILED **");
        end
        $finish;
    end

endmodule

FILE: filelist.f
src/boxds_pkg.sv
src/boxds_ram.sv
src/boxds_outq.sv
src/box_average_downscale.sv
sim/box_average_downscale_checker.sv
sim/tb_box_average_downscale.sv
